@@ design/ckvl_pkg.sv @@
// ----------------------------------------------------------------------------
// ckvl_pkg: shared definitions for the canonical k-mer vertex lookup
// Table depth default, key widths and the configuration register indexes.
// ----------------------------------------------------------------------------
package ckvl_pkg;

  // Default number of table slots.
  localparam int unsigned TABLE_DEPTH_DFLT = 4096;

  // A k-mer is up to 63 bases of 2 bits, held as two 64-bit halves.
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned KEY_W    = 2 * HALF_W;
  localparam int unsigned BASES    = KEY_W / 2;

  // Field widths of the transaction and configuration ports.
  localparam int unsigned KLEN_W   = 6;
  localparam int unsigned VCNT_W   = 13;
  localparam int unsigned CMASK_W  = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned VID_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KMER_LENGTH     = 2'd0,
    CFG_VERTEX_COUNT    = 2'd1,
    CFG_COMPLEMENT_MASK = 2'd2
  } cfg_reg_t;

  // Transaction action codes.
  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  // Reset values of the configuration registers.
  localparam logic [KLEN_W-1:0]  KLEN_RST  = 6'd31;
  localparam logic [VCNT_W-1:0]  VCNT_RST  = 13'd0;
  localparam logic [CMASK_W-1:0] CMASK_RST = 2'd2;

endpackage

@@ design/ckvl_ram.sv @@
// ----------------------------------------------------------------------------
// ckvl_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ckvl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/canonical_kmer_vertex_lookup.sv @@
// ----------------------------------------------------------------------------
// canonical_kmer_vertex_lookup: canonical k-mer table with binary search
// Write transactions load sorted 128-bit keys; lookup transactions form the
// reverse complement of the query, pick the canonical form and search it.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+-------------------
//  input    | in_action, in_entry_index, in_kmer_high/low  | start && !busy
//  result   | out_found, out_vertex_id, out_reverse_strand | out_valid, 1 cycle
//  config   | cfg_index, cfg_wdata                         | cfg_we
//
// A write transaction leaves busy low.
// A lookup keeps busy high through the reversal and canonical selection steps
// and a probe step and an evaluate step for each of P probes, plus a final
// probe step on a miss; P is at most ceil(log2(n+1)) for n valid entries.
// The result strobe rises in the same cycle in which busy falls.
// Each probe has one step for the registered read of the key memory and
// one for the shared 128-bit compare; that loop sets the lookup time.
// Reset is synchronous and active low; the key memory is not cleared.
// The receiver cannot stall: out_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
module canonical_kmer_vertex_lookup #(
  parameter int unsigned TABLE_DEPTH = ckvl_pkg::TABLE_DEPTH_DFLT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_action,
  input  logic [ckvl_pkg::IDX_W-1:0]       in_entry_index,
  input  logic [ckvl_pkg::HALF_W-1:0]      in_kmer_high,
  input  logic [ckvl_pkg::HALF_W-1:0]      in_kmer_low,
  // Result channel
  output logic                             out_valid,
  output logic                             out_found,
  output logic [ckvl_pkg::VID_W-1:0]       out_vertex_id,
  output logic                             out_reverse_strand,
  // Configuration port
  input  logic                             cfg_we,
  input  logic [ckvl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ckvl_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = ckvl_pkg::KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REV,
    S_SEL,
    S_PROBE,
    S_EVAL
  } state_t;

  // Configuration registers.
  logic [ckvl_pkg::KLEN_W-1:0]  klen_r;
  logic [ckvl_pkg::VCNT_W-1:0]  vcnt_r;
  logic [ckvl_pkg::CMASK_W-1:0] cmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r  <= ckvl_pkg::KLEN_RST;
      vcnt_r  <= ckvl_pkg::VCNT_RST;
      cmask_r <= ckvl_pkg::CMASK_RST;
    end else if (cfg_we) begin
      case (ckvl_pkg::cfg_reg_t'(cfg_index))
        ckvl_pkg::CFG_KMER_LENGTH:     klen_r  <= cfg_wdata[ckvl_pkg::KLEN_W-1:0];
        ckvl_pkg::CFG_VERTEX_COUNT:    vcnt_r  <= cfg_wdata[ckvl_pkg::VCNT_W-1:0];
        ckvl_pkg::CFG_COMPLEMENT_MASK: cmask_r <= cfg_wdata[ckvl_pkg::CMASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers.
  state_t         state_r, state_nxt;
  logic [KW-1:0]  query_r, query_nxt;
  logic [KW-1:0]  rc_r, rc_nxt;
  logic [KW-1:0]  target_r, target_nxt;
  logic           rev_r, rev_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;        // exclusive upper bound
  logic [AW-1:0]  mid_r, mid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  logic [ckvl_pkg::VID_W-1:0] out_vid_r, out_vid_nxt;
  logic           out_rev_r, out_rev_nxt;

  // Key memory ports.
  logic [ckvl_pkg::HALF_W-1:0] rd_high, rd_low;
  logic [KW-1:0]               entry;
  logic                        wr_en;
  logic [31:0]                 wr_idx_ext;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  // Handshake decode.
  logic accept;
  assign accept = start && (state_r == S_IDLE);

  // Writes to slots beyond the table are dropped.
  assign wr_idx_ext = 32'(in_entry_index);
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign wr_en      = accept && (ckvl_pkg::action_t'(in_action) == ckvl_pkg::ACT_WRITE)
                      && (wr_idx_ext < 32'(TABLE_DEPTH));

  ckvl_ram #(.WIDTH(ckvl_pkg::HALF_W), .DEPTH(TABLE_DEPTH)) u_key_high (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_kmer_high),
    .raddr (rd_addr),
    .rdata (rd_high)
  );

  ckvl_ram #(.WIDTH(ckvl_pkg::HALF_W), .DEPTH(TABLE_DEPTH)) u_key_low (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_kmer_low),
    .raddr (rd_addr),
    .rdata (rd_low)
  );

  assign entry = {rd_high, rd_low};

  // Base reversal with complement over all 64 positions; the shift then drops
  // the positions beyond the k-mer length.
  logic [KW-1:0] perm;
  logic [7:0]    rc_shift;

  always_comb begin
    for (int b = 0; b < ckvl_pkg::BASES; b++) begin
      perm[2*(ckvl_pkg::BASES-1-b) +: 2] = query_r[2*b +: 2] ^ cmask_r;
    end
  end

  assign rc_shift = {(7'(ckvl_pkg::BASES) - {1'b0, klen_r}), 1'b0};

  // Effective entry count, limited to the table depth.
  logic [CW-1:0] n_eff;
  assign n_eff = (32'(vcnt_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(vcnt_r);

  // Probe midpoint of the inclusive range lo .. hi-1.
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_calc;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_calc = mid_sum[AW:1];
  assign rd_addr  = mid_calc;

  // Result index, offset by the count on the reverse strand.
  logic [31:0] vid_sum;
  assign vid_sum = 32'(mid_r) + (rev_r ? 32'(n_r) : 32'd0);

  // Shared 128-bit compare: the query against its complement while the form is
  // chosen, then the probed entry against the target during the search.
  logic [KW-1:0] cmp_a, cmp_b;
  logic          cmp_eq, cmp_lt;
  assign cmp_a  = (state_r == S_SEL) ? query_r : entry;
  assign cmp_b  = (state_r == S_SEL) ? rc_r : target_r;
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    query_nxt     = query_r;
    rc_nxt        = rc_r;
    target_nxt    = target_r;
    rev_nxt       = rev_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_vid_nxt   = out_vid_r;
    out_rev_nxt   = out_rev_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (ckvl_pkg::action_t'(in_action) == ckvl_pkg::ACT_LOOKUP)) begin
          query_nxt = {in_kmer_high, in_kmer_low};
          state_nxt = S_REV;
        end
      end
      S_REV: begin
        rc_nxt    = (klen_r == '0) ? '0 : (perm >> rc_shift);
        state_nxt = S_SEL;
      end
      S_SEL: begin
        // The query is canonical only when strictly below its complement.
        rev_nxt    = !cmp_lt;
        target_nxt = cmp_lt ? query_r : rc_r;
        n_nxt      = n_eff;
        lo_nxt     = '0;
        hi_nxt     = n_eff;
        state_nxt  = S_PROBE;
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          state_nxt = S_EVAL;
        end else begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_vid_nxt   = '0;
          out_rev_nxt   = rev_r;
          state_nxt     = S_IDLE;
        end
      end
      S_EVAL: begin
        if (cmp_eq) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_vid_nxt   = vid_sum[ckvl_pkg::VID_W-1:0];
          out_rev_nxt   = rev_r;
          state_nxt     = S_IDLE;
        end else begin
          if (cmp_lt) begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end else begin
            hi_nxt = CW'(mid_r);
          end
          state_nxt = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_vid_r   <= '0;
      out_rev_r   <= 1'b0;
      rev_r       <= 1'b0;
      n_r         <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      mid_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
      out_vid_r   <= out_vid_nxt;
      out_rev_r   <= out_rev_nxt;
      rev_r       <= rev_nxt;
      n_r         <= n_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      mid_r       <= mid_nxt;
    end
  end

  // Wide datapath registers carry no reset.
  always_ff @(posedge clk) begin
    query_r  <= query_nxt;
    rc_r     <= rc_nxt;
    target_r <= target_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_vertex_id      = out_vid_r;
  assign out_reverse_strand = out_rev_r;

  // A result only follows a search that was in progress.
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_PROBE || $past(state_r) == S_EVAL))
    else $error("result strobe without a search in progress");

  // A miss always reports index zero.
  a_miss_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_vertex_id == '0))
    else $error("not-found result carries a non-zero index");

  // The search window never inverts and stays inside the entry count.
  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_EVAL) |-> (lo_r <= hi_r && hi_r <= n_r))
    else $error("search bounds out of order");

  // Each probed slot lies inside the current window.
  a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (CW'(mid_r) >= lo_r && CW'(mid_r) < hi_r))
    else $error("probe outside the search window");

  // An accepted lookup makes the block busy in the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action) |=> busy)
    else $error("accepted lookup did not start a search");

endmodule
